[rtl/json_token_lexer_assert.svh]
// Assertion macros shared by the lexer RTL.
`ifndef JSON_TOKEN_LEXER_ASSERT_SVH
`define JSON_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JTL_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JTL_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/jtl_pkg.sv]
// Types, codes and character constants for the JSON token lexer.
`default_nettype none
package jtl_pkg;

	typedef enum logic [3:0] {
		K_STRING = 4'd0,
		K_NUMBER = 4'd1,
		K_BOOL   = 4'd2,
		K_NULL   = 4'd3,
		K_COPEN  = 4'd4,
		K_CCLOSE = 4'd5,
		K_AOPEN  = 4'd6,
		K_ACLOSE = 4'd7,
		K_COLON  = 4'd8,
		K_COMMA  = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE   = 3'd0,
		E_TRAIL  = 3'd1,
		E_BADNUM = 3'd2,
		E_UNEXP  = 3'd3,
		E_ENDED  = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_STR  = 4'b0010,
		M_NUM  = 4'b0100,
		M_SKIP = 4'b1000
	} mode_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] vbyte;
		logic       bvalid;
		logic       tend;
		logic       bval;
		err_t       err;
	} res_t;

	localparam res_t RES_NONE = '{kind: K_STRING, vbyte: 8'h00, bvalid: 1'b0,
		tend: 1'b0, bval: 1'b0, err: E_NONE};

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COPEN  = 8'h7B;
	localparam logic [7:0] CH_CCLOSE = 8'h7D;
	localparam logic [7:0] CH_AOPEN  = 8'h5B;
	localparam logic [7:0] CH_ACLOSE = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_N      = 8'h6E;

	localparam logic [2:0] SKIP_FALSE = 3'd4;
	localparam logic [2:0] SKIP_OTHER = 3'd3;

endpackage
`default_nettype wire

[rtl/json_token_lexer.sv]
// Top level of the streaming JSON token lexer.
//
//   channel   dir  tdata                        tlast       tuser
//   s_axis    in   [7:0] in_byte                is_last     -
//   m_axis    out  [7:0] value_byte, [8] byte_  token_end   [3:0] token_kind
//                  valid, [9] bool_value,
//                  [12:10] error_code
//
// One byte is taken per cycle while m_axis is ready; a byte that yields two results (comma
// after a number, error after a final string or letter byte) holds the input until one is out.
// The first result shows in the cycle after the input transfer, from the result buffer.
// Reset clears the lex mode to idle, the skip count to zero and empties the buffer.
// A stall on m_axis back-pressures s_axis once the buffer holds a result it cannot pass on.
`default_nettype none
module json_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] value_byte, [8] byte_valid, [9] bool_value,
	                                    // [12:10] error_code, [15:13] zero
	output logic        m_axis_tlast,
	output logic [3:0]  m_axis_tuser    // [3:0] token_kind
);
	import jtl_pkg::*;

	`include "json_token_lexer_assert.svh"

	mode_t      mode_q;
	logic [2:0] skip_q;
	mode_t      mode_nxt;
	logic [2:0] skip_nxt;
	logic [1:0] res_cnt;
	res_t       res0;
	res_t       res1;
	res_t       head;
	logic       in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	jtl_decode u_decode (
		.mode      (mode_q),
		.skip_left (skip_q),
		.in_byte   (s_axis_tdata),
		.is_last   (s_axis_tlast),
		.mode_nxt  (mode_nxt),
		.skip_nxt  (skip_nxt),
		.res_cnt   (res_cnt),
		.res0      (res0),
		.res1      (res1)
	);

	jtl_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_xfer),
		.push_cnt   (res_cnt),
		.push_r0    (res0),
		.push_r1    (res1),
		.push_ready (s_axis_tready),
		.head       (head),
		.head_valid (m_axis_tvalid),
		.head_ready (m_axis_tready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			skip_q <= 3'd0;
		end else if (in_xfer) begin
			mode_q <= mode_nxt;
			skip_q <= skip_nxt;
		end
	end

	assign m_axis_tdata = {3'b000, head.err, head.bval, head.bvalid, head.vbyte};
	assign m_axis_tlast = head.tend;
	assign m_axis_tuser = head.kind;

	`JTL_ASSERT_NOW(a_skip_count, clk, arst_n, 1'b1, (mode_q == M_SKIP) == (skip_q != 3'd0), "skip count out of step with mode")
	`JTL_ASSERT_NEXT(a_last_idle, clk, arst_n, in_xfer && s_axis_tlast, mode_q == M_IDLE, "lexer not idle after final byte")

endmodule
`default_nettype wire

[rtl/jtl_decode.sv]
// Next-state and result decode for one input byte.
`default_nettype none
module jtl_decode (
	input  jtl_pkg::mode_t      mode,
	input  logic [2:0]          skip_left,
	input  logic [7:0]          in_byte,
	input  logic                is_last,
	output jtl_pkg::mode_t      mode_nxt,
	output logic [2:0]          skip_nxt,
	output logic [1:0]          res_cnt,
	output jtl_pkg::res_t       res0,
	output jtl_pkg::res_t       res1
);
	import jtl_pkg::*;

	function automatic res_t mk_tok(kind_t k, logic bv);
		res_t r;
		r      = RES_NONE;
		r.kind = k;
		r.tend = 1'b1;
		r.bval = bv;
		return r;
	endfunction

	function automatic res_t mk_byte(kind_t k, logic [7:0] c, logic e);
		res_t r;
		r        = RES_NONE;
		r.kind   = k;
		r.vbyte  = c;
		r.bvalid = 1'b1;
		r.tend   = e;
		return r;
	endfunction

	function automatic res_t mk_err(err_t e);
		res_t r;
		r     = RES_NONE;
		r.err = e;
		return r;
	endfunction

	logic       is_digit;
	logic       is_numc;
	logic [2:0] skip_dec;

	assign is_digit = in_byte inside {[CH_ZERO:CH_NINE]};
	assign is_numc  = is_digit || (in_byte == CH_MINUS) || (in_byte == CH_DOT);
	assign skip_dec = (skip_left != 3'd0) ? skip_left - 3'd1 : 3'd0;

	always_comb begin
		mode_nxt = mode;
		skip_nxt = skip_left;
		res_cnt  = 2'd0;
		res0     = RES_NONE;
		res1     = RES_NONE;
		case (mode)
			M_IDLE: begin
				if (in_byte == CH_SPACE || in_byte == CH_LF) begin
					if (is_last) begin
						res0    = mk_err(E_TRAIL);
						res_cnt = 2'd1;
					end
				end else if (in_byte == CH_QUOTE) begin
					if (is_last) begin
						res0    = mk_err(E_ENDED);
						res_cnt = 2'd1;
					end else begin
						mode_nxt = M_STR;
					end
				end else if (in_byte == CH_MINUS || is_digit) begin
					res0    = mk_byte(K_NUMBER, in_byte, is_last);
					res_cnt = 2'd1;
					if (!is_last)
						mode_nxt = M_NUM;
				end else if (in_byte == CH_F || in_byte == CH_T || in_byte == CH_N) begin
					if (in_byte == CH_N)
						res0 = mk_tok(K_NULL, 1'b0);
					else
						res0 = mk_tok(K_BOOL, in_byte == CH_T);
					res_cnt = 2'd1;
					if (is_last) begin
						res1    = mk_err(E_ENDED);
						res_cnt = 2'd2;
					end else begin
						skip_nxt = (in_byte == CH_F) ? SKIP_FALSE : SKIP_OTHER;
						mode_nxt = M_SKIP;
					end
				end else begin
					res_cnt = 2'd1;
					case (in_byte)
						CH_COPEN:  res0 = mk_tok(K_COPEN, 1'b0);
						CH_CCLOSE: res0 = mk_tok(K_CCLOSE, 1'b0);
						CH_AOPEN:  res0 = mk_tok(K_AOPEN, 1'b0);
						CH_ACLOSE: res0 = mk_tok(K_ACLOSE, 1'b0);
						CH_COLON:  res0 = mk_tok(K_COLON, 1'b0);
						CH_COMMA:  res0 = mk_tok(K_COMMA, 1'b0);
						default:   res0 = mk_err(E_UNEXP);
					endcase
				end
			end
			M_STR: begin
				if (in_byte == CH_QUOTE) begin
					res0     = mk_tok(K_STRING, 1'b0);
					res_cnt  = 2'd1;
					mode_nxt = M_IDLE;
				end else begin
					res0    = mk_byte(K_STRING, in_byte, 1'b0);
					res_cnt = 2'd1;
					if (is_last) begin
						res1    = mk_err(E_ENDED);
						res_cnt = 2'd2;
					end
				end
			end
			M_NUM: begin
				res_cnt = 2'd1;
				if (is_last) begin
					res0 = mk_tok(K_NUMBER, 1'b0);
				end else if (is_numc) begin
					res0 = mk_byte(K_NUMBER, in_byte, 1'b0);
				end else if (in_byte == CH_COMMA) begin
					res0     = mk_tok(K_NUMBER, 1'b0);
					res1     = mk_tok(K_COMMA, 1'b0);
					res_cnt  = 2'd2;
					mode_nxt = M_IDLE;
				end else if (in_byte == CH_LF) begin
					res0     = mk_tok(K_NUMBER, 1'b0);
					mode_nxt = M_IDLE;
				end else begin
					res0     = mk_err(E_BADNUM);
					mode_nxt = M_IDLE;
				end
			end
			M_SKIP: begin
				skip_nxt = skip_dec;
				if (skip_dec == 3'd0) begin
					mode_nxt = M_IDLE;
				end else if (is_last) begin
					res0    = mk_err(E_ENDED);
					res_cnt = 2'd1;
				end
			end
			default: begin
				mode_nxt = M_IDLE;
				skip_nxt = 3'd0;
			end
		endcase
		// the final byte always leaves the lexer idle
		if (is_last) begin
			mode_nxt = M_IDLE;
			skip_nxt = 3'd0;
		end
	end

endmodule
`default_nettype wire

[rtl/jtl_outbuf.sv]
// Two-slot result buffer between the decode and the output stream.
`default_nettype none
module jtl_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [1:0]     push_cnt,
	input  jtl_pkg::res_t  push_r0,
	input  jtl_pkg::res_t  push_r1,
	output logic           push_ready,
	output jtl_pkg::res_t  head,
	output logic           head_valid,
	input  logic           head_ready
);
	import jtl_pkg::*;

	`include "json_token_lexer_assert.svh"

	res_t       slot0_q;
	res_t       slot1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop        = head_valid && head_ready;
	assign head_valid = cnt_q != 2'd0;
	assign head       = slot0_q;
	// a new item only lands when the buffer is empty after this cycle's transfer
	assign push_ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && head_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= push_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= push_r0;
			slot1_q <= push_r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	`JTL_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3, "result count out of range")
	`JTL_ASSERT_NOW(a_no_overwrite, clk, arst_n, push, (cnt_q == 2'd0) || pop, "results overwritten")
	`JTL_ASSERT_NEXT(a_drain_second, clk, arst_n, pop && !push && (cnt_q == 2'd2), (cnt_q == 2'd1) && head_valid, "second result lost")

endmodule
`default_nettype wire
